// File: rtl/mms_pkg.sv
`default_nettype none

package mms_pkg;

    // Storage geometry and field widths
    localparam int DEPTH    = 64;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = 7;
    localparam int VAL_W    = 16;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    // Value constants
    localparam logic signed [VAL_W-1:0] VAL_MAX     = 16'sh7FFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN     = 16'sh8000;
    localparam logic signed [VAL_W-1:0] VAL_NEG_ONE = 16'shFFFF;
    localparam logic signed [VAL_W-1:0] VAL_ZERO    = 16'sh0000;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    // Register addresses (word index, taken from paddr[2])
    localparam logic REG_CAPACITY = 1'b0;

    // Source of the result value
    typedef enum logic [1:0] {
        VSEL_ZERO = 2'd0,
        VSEL_TOP  = 2'd1,
        VSEL_NEG1 = 2'd2
    } vsel_t;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] data;
    } mms_req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] min_value;
        logic signed [VAL_W-1:0] max_value;
        logic [CNT_W-1:0]        count;
        logic                    empty_res;
        logic                    full_res;
    } mms_rsp_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] val;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
    } mms_entry_t;

    // Controller to datapath
    typedef struct packed {
        logic              do_push;
        logic              do_pop;
        logic              do_refill;
        logic              load_value;
        vsel_t             vsel;
        logic [STAT_W-1:0] status;
        logic              emit;
    } mms_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic single;
        logic at_cap;
        logic out_busy;
    } mms_stat_t;

endpackage

`default_nettype wire

// File: rtl/min_max_stack_top.sv
`default_nettype none

// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+--------------------------------------
// req      | in        | req_valid / req_stall | op, data
// rsp      | out       | rsp_valid / rsp_stall | value, status, min/max, count, flags
// apb      | in/out    | psel, penable, pready | capacity at byte address 0
//
// Push, peek, errors and a pop that empties the stack emit their result on acceptance.
// A pop that leaves one or more entries emits from S_FILL: the registered read port of
// the stack memory fetches the new top entry with its running min and max.
// The result lands in an output register; a new request is taken while it waits,
// unless the result is stalled.
// Reset clears the count, the extremes and the output valid; no clearing pass.

module min_max_stack_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output      logic                            req_stall,
    input  wire mms_pkg::mms_req_t               req,
    output      logic                            rsp_valid,
    input  wire logic                            rsp_stall,
    output      mms_pkg::mms_rsp_t               rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mms_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [mms_pkg::PDATA_W-1:0]     pwdata,
    output      logic [mms_pkg::PDATA_W-1:0]     prdata,
    output      logic                            pready
);
    import mms_pkg::*;

    logic [CNT_W-1:0] capacity_reg;
    logic             cfg_write;
    mms_cmd_t         cmd;
    mms_stat_t        stat;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign prdata    = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAP_RESET;
        else if (cfg_write)
            capacity_reg <= pwdata[CNT_W-1:0];
    end

    mms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req.op),
        .stat      (stat),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    mms_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .push_data (req.data),
        .capacity  (capacity_reg),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// File: rtl/mms_datapath.sv
`default_nettype none

module mms_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire mms_pkg::mms_cmd_t                   cmd,
    output      mms_pkg::mms_stat_t                  stat,
    input  wire logic signed [mms_pkg::VAL_W-1:0]    push_data,
    input  wire logic [mms_pkg::CNT_W-1:0]           capacity,
    input  wire logic                                rsp_stall,
    output      logic                                rsp_valid,
    output      mms_pkg::mms_rsp_t                   rsp
);
    import mms_pkg::*;

    mms_entry_t mem [DEPTH];
    mms_entry_t rd_data_reg;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [VAL_W-1:0] top_val_reg, top_val_next;
    logic signed [VAL_W-1:0] top_lo_reg, top_lo_next;
    logic signed [VAL_W-1:0] top_hi_reg, top_hi_next;
    logic signed [VAL_W-1:0] push_lo, push_hi;
    logic signed [VAL_W-1:0] sel_value;
    logic [CNT_W-1:0]        cap_eff;
    logic [CNT_W-1:0]        rd_cnt;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    rsp_valid_reg, rsp_valid_next;
    mms_rsp_t                rsp_reg, rsp_next;

    // Saturate capacity to the storage depth
    assign cap_eff = (capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;

    assign stat.empty    = (count_reg == '0);
    assign stat.single   = (count_reg == CNT_W'(1));
    assign stat.at_cap   = (count_reg >= cap_eff);
    assign stat.out_busy = rsp_valid_reg && rsp_stall;

    // Running extremes for a new top entry
    assign push_lo = (push_data < top_lo_reg) ? push_data : top_lo_reg;
    assign push_hi = (push_data > top_hi_reg) ? push_data : top_hi_reg;

    // Entry below the current top, fetched for a refill after pop
    assign rd_cnt  = count_reg - CNT_W'(2);
    assign rd_addr = rd_cnt[ADDR_W-1:0];

    // Top-of-stack next state
    always_comb
    begin
        count_next   = count_reg;
        top_val_next = top_val_reg;
        top_lo_next  = top_lo_reg;
        top_hi_next  = top_hi_reg;
        if (cmd.do_push)
        begin
            count_next   = count_reg + CNT_W'(1);
            top_val_next = push_data;
            top_lo_next  = push_lo;
            top_hi_next  = push_hi;
        end
        else if (cmd.do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                top_lo_next = VAL_MAX;
                top_hi_next = VAL_MIN;
            end
        end
        else if (cmd.do_refill)
        begin
            top_val_next = rd_data_reg.val;
            top_lo_next  = rd_data_reg.lo;
            top_hi_next  = rd_data_reg.hi;
        end
    end

    // Result value by selection
    always_comb
    begin
        case (cmd.vsel)
            VSEL_TOP:  sel_value = top_val_reg;
            VSEL_NEG1: sel_value = VAL_NEG_ONE;
            default:   sel_value = VAL_ZERO;
        endcase
    end

    // Output register: value and status at acceptance, the rest on emit
    always_comb
    begin
        rsp_next = rsp_reg;
        if (cmd.load_value)
        begin
            rsp_next.value  = sel_value;
            rsp_next.status = cmd.status;
        end
        if (cmd.emit)
        begin
            rsp_next.min_value = top_lo_next;
            rsp_next.max_value = top_hi_next;
            rsp_next.count     = count_next;
            rsp_next.empty_res = (count_next == '0);
            rsp_next.full_res  = (count_next == cap_eff);
        end
        if (cmd.emit)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    // Stack storage: write on push, registered read of the entry below top
    always_ff @(posedge clk)
    begin
        if (cmd.do_push)
            mem[count_reg[ADDR_W-1:0]] <= '{val: push_data, lo: push_lo, hi: push_hi};
        rd_data_reg <= mem[rd_addr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            top_lo_reg    <= VAL_MAX;
            top_hi_reg    <= VAL_MIN;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            top_lo_reg    <= top_lo_next;
            top_hi_reg    <= top_hi_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        top_val_reg <= top_val_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("stack count above depth");

    a_empty_extremes: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (top_lo_reg == VAL_MAX && top_hi_reg == VAL_MIN))
        else $error("empty stack with stale extremes");

    a_lo_le_hi: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (top_lo_reg <= top_hi_reg))
        else $error("running min above running max");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(rsp_valid_reg && rsp_stall))
        else $error("result emitted over a stalled result");

endmodule

`default_nettype wire

// File: rtl/mms_ctrl.sv
`default_nettype none

module mms_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    input  wire logic [mms_pkg::OP_W-1:0]   req_op,
    input  wire mms_pkg::mms_stat_t         stat,
    output      mms_pkg::mms_cmd_t          cmd,
    output      logic                       req_stall
);
    import mms_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FILL = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    // Take a request only in idle with room in the output register
    assign req_stall = (state_reg != S_IDLE) || stat.out_busy;
    assign accept    = req_valid && !req_stall;

    // Decode the request into datapath commands
    always_comb
    begin
        cmd        = '0;
        cmd.vsel   = VSEL_ZERO;
        cmd.status = ST_OK;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_value = 1'b1;
                    cmd.emit       = 1'b1;
                    case (req_op)
                        OP_PUSH:
                        begin
                            if (stat.at_cap)
                                cmd.status = ST_OVERFLOW;
                            else
                                cmd.do_push = 1'b1;
                        end
                        OP_POP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.status = ST_UNDERFLOW;
                                cmd.vsel   = VSEL_NEG1;
                            end
                            else
                            begin
                                cmd.do_pop = 1'b1;
                                cmd.vsel   = VSEL_TOP;
                                // Deeper entry becomes top: fetch it first
                                if (!stat.single)
                                begin
                                    cmd.emit   = 1'b0;
                                    state_next = S_FILL;
                                end
                            end
                        end
                        OP_PEEK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.status = ST_UNDERFLOW;
                                cmd.vsel   = VSEL_NEG1;
                            end
                            else
                                cmd.vsel = VSEL_TOP;
                        end
                        default:
                        begin
                            cmd.status = ST_OK;
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                cmd.do_refill = 1'b1;
                cmd.emit      = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Checks
    a_fill_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |=> (state_reg == S_IDLE))
        else $error("refill lasted more than one cycle");

    a_deep_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_op == OP_POP && !stat.empty && !stat.single)
            |=> (state_reg == S_FILL))
        else $error("pop of a deep stack skipped the refill");

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import mms_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PHASES = 12;
    localparam int CAP_RANDOM = -1;

    typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_t;

    // Capacity and request mix of each random phase
    int   phase_cap [NUM_PHASES] = '{127, 10, 64, 1, 0, CAP_RANDOM, 64, 2, 100, CAP_RANDOM,
                                     40, 64};
    mix_t phase_mix [NUM_PHASES] = '{MIX_FILL, MIX_EVEN, MIX_FILL, MIX_DRAIN, MIX_EVEN,
                                     MIX_DRAIN, MIX_FILL, MIX_EVEN, MIX_FILL, MIX_DRAIN,
                                     MIX_EVEN, MIX_DRAIN};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    mms_req_t           req = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    mms_rsp_t           rsp;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Shadow copy of the stack: each slot keeps value and running extremes
    mms_entry_t         stack_shadow [DEPTH];
    int                 held = 0;
    logic [CNT_W-1:0]   cap_reg = CAP_RESET;

    mms_req_t           pending_reqs [$];
    mms_rsp_t           expected_rsps [$];
    int                 items_queued = 0;
    int                 items_taken = 0;
    int                 errors = 0;
    int                 quiet_cycles = 0;
    bit                 req_taken = 1'b0;
    bit                 idle_on = 1'b1;
    int                 feed_gap = 0;
    int                 stall_left = 0;
    int                 hold_left = 0;
    int                 pressure_ask = 0;
    int                 pressure_seen = 0;

    min_max_stack_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // Apply one request to the shadow stack and return the result it gives
    function automatic mms_rsp_t stack_apply(input mms_req_t r);
        mms_rsp_t               o;
        int                     cap_lim;
        logic signed [VAL_W-1:0] d;
        logic signed [VAL_W-1:0] plo;
        logic signed [VAL_W-1:0] phi;
        cap_lim = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
        d = r.data;
        o = '0;
        o.value = VAL_ZERO;
        o.status = ST_OK;
        case (r.op)
            OP_PUSH:
            begin
                if (held >= cap_lim)
                    o.status = ST_OVERFLOW;
                else
                begin
                    plo = (held == 0) ? VAL_MAX : stack_shadow[held-1].lo;
                    phi = (held == 0) ? VAL_MIN : stack_shadow[held-1].hi;
                    stack_shadow[held].val = d;
                    stack_shadow[held].lo = (d < plo) ? d : plo;
                    stack_shadow[held].hi = (d > phi) ? d : phi;
                    held++;
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (held == 0)
                begin
                    o.status = ST_UNDERFLOW;
                    o.value = VAL_NEG_ONE;
                end
                else
                begin
                    o.value = stack_shadow[held-1].val;
                    if (r.op == OP_POP)
                        held--;
                end
            end
            default:
            begin
            end
        endcase
        o.min_value = (held == 0) ? VAL_MAX : stack_shadow[held-1].lo;
        o.max_value = (held == 0) ? VAL_MIN : stack_shadow[held-1].hi;
        o.count = CNT_W'(held);
        o.empty_res = (held == 0);
        o.full_res = (held == cap_lim);
        return o;
    endfunction

    function automatic void cmp_field(input string nm, input logic [VAL_W-1:0] want,
                                      input logic [VAL_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, nm, want, got);
            errors++;
        end
    endfunction

    // Compare one result transfer against the oldest expectation
    function automatic void check_rsp(input mms_rsp_t got);
        mms_rsp_t want;
        if (expected_rsps.size() == 0)
        begin
            $display("%0t: unexpected result, expected none actual %p", $time, got);
            errors++;
        end
        else
        begin
            want = expected_rsps.pop_front();
            cmp_field("value", want.value, got.value);
            cmp_field("status", VAL_W'(want.status), VAL_W'(got.status));
            cmp_field("min_value", want.min_value, got.min_value);
            cmp_field("max_value", want.max_value, got.max_value);
            cmp_field("count", VAL_W'(want.count), VAL_W'(got.count));
            cmp_field("empty_res", VAL_W'(want.empty_res), VAL_W'(got.empty_res));
            cmp_field("full_res", VAL_W'(want.full_res), VAL_W'(got.full_res));
        end
    endfunction

    // Monitor: predict on each request transfer, check each result transfer
    always @(posedge clk)
    begin : monitor
        bit moved;
        moved = 1'b0;
        req_taken = 1'b0;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                check_rsp(rsp);
                moved = 1'b1;
            end
            if (req_valid && !req_stall)
            begin
                expected_rsps.push_back(stack_apply(req));
                items_taken++;
                req_taken = 1'b1;
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Driver: present queued requests, hold a stalled one, insert gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_taken)
        begin
            if (feed_gap > 0)
            begin
                feed_gap--;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                feed_gap = idle_on ? gap_len() : 0;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (pressure_seen != pressure_ask)
        begin
            pressure_seen = pressure_ask;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            stall_left = idle_on ? gap_len() : 0;
        end
    end

    task automatic queue_req(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] d);
        mms_req_t r;
        r.op = op;
        r.data = d;
        pending_reqs.push_back(r);
        items_queued++;
    endtask

    // Wait until every queued request has been taken and answered
    task automatic wait_drained();
        while (items_taken != items_queued || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    // Write the capacity register, then read it back
    task automatic set_capacity(input logic [CNT_W-1:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_CAPACITY, 2'b00};
        pwdata <= PDATA_W'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        cap_reg = v;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== PDATA_W'(v))
        begin
            $display("%0t: capacity readback mismatch, expected %h actual %h",
                     $time, PDATA_W'(v), prdata);
            errors++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic signed [VAL_W-1:0] pick_data();
        case ($urandom_range(0, 9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return VAL_NEG_ONE;
            3: return VAL_ZERO;
            default: return VAL_W'($urandom());
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input mix_t mix);
        int push_pct;
        int r;
        push_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_EVEN) ? 45 : 20;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return OP_PUSH;
        else if (r >= 96)
            return OP_NOP;
        return ($urandom_range(0, 9) < 7) ? OP_POP : OP_PEEK;
    endfunction

    initial
    begin
        int n;
        logic [CNT_W-1:0] cap;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: underflow, nop, extremes, full and overflow at capacity three
        set_capacity(7'd3);
        queue_req(OP_POP, 16'sh1234);
        queue_req(OP_PEEK, VAL_ZERO);
        queue_req(OP_NOP, 16'sh5A5A);
        queue_req(OP_PUSH, VAL_MAX);
        queue_req(OP_PUSH, VAL_MIN);
        queue_req(OP_PEEK, VAL_ZERO);
        queue_req(OP_PUSH, VAL_ZERO);
        queue_req(OP_PUSH, 16'sh0005);
        queue_req(OP_POP, VAL_ZERO);
        queue_req(OP_POP, VAL_ZERO);
        queue_req(OP_PEEK, VAL_ZERO);
        queue_req(OP_POP, VAL_ZERO);
        queue_req(OP_POP, VAL_ZERO);
        queue_req(OP_PUSH, VAL_NEG_ONE);
        queue_req(OP_NOP, VAL_MIN);
        queue_req(OP_POP, VAL_MAX);
        wait_drained();

        // Directed: capacity zero overflows every push and reads full while empty
        set_capacity(7'd0);
        queue_req(OP_PUSH, 16'sh0007);
        queue_req(OP_PEEK, VAL_ZERO);
        queue_req(OP_POP, VAL_ZERO);
        wait_drained();

        // Random phases; the stack carries over so capacity drops below count
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            cap = (phase_cap[p] == CAP_RANDOM) ? CNT_W'($urandom_range(0, 127))
                                               : CNT_W'(phase_cap[p]);
            set_capacity(cap);
            idle_on = (p % 4 != 3);
            if (p == 2)
                pressure_ask++;
            n = (phase_mix[p] == MIX_FILL) ? 70 : 35;
            for (int i = 0; i < n; i++)
                queue_req(pick_op(phase_mix[p]), pick_data());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: files.f
rtl/mms_pkg.sv
rtl/mms_datapath.sv
rtl/mms_ctrl.sv
rtl/min_max_stack_top.sv
dv/tb.sv
